FILE: src/nearest_landmark_association_assert.svh
// Assertion macros for the nearest landmark association block.
// Used by the top level only; clk and rst_n must be in scope at each use.
`ifndef NEAREST_LANDMARK_ASSOCIATION_ASSERT_SVH
`define NEAREST_LANDMARK_ASSOCIATION_ASSERT_SVH
`ifndef SYNTHESIS
`define NLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NLA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NLA_ASSERT(lbl, prop, msg)
`define NLA_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/nla_pkg.sv
// Shared types and constants of the nearest landmark association block.
// No dependencies; used by nla_dist, nearest_landmark_association and the testbench.
`default_nettype none

package nla_pkg;

    localparam int MAX_MARKS_DEF = 64;

    localparam int COORD_W = 24;
    localparam int TAG_W   = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int DIST_W  = 50;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TAG_W-1:0]          tag;
    } nla_entry_t;

    // one landmark travelling into the distance unit
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        nla_entry_t entry;
    } nla_probe_t;

    // one squared distance leaving the distance unit
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sq_sum;
    } nla_dist_t;

endpackage

`default_nettype wire

FILE: src/nla_dist.sv
// Three-stage squared Euclidean distance unit: abs difference, squares, sum.
// Depends on nla_pkg for the probe and result structs.
`default_nettype none

module nla_dist
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire nla_pkg::nla_probe_t               probe,
    input  wire logic signed [nla_pkg::COORD_W-1:0] obs_x,
    input  wire logic signed [nla_pkg::COORD_W-1:0] obs_y,
    output nla_pkg::nla_dist_t                     result
);

    localparam int CW = nla_pkg::COORD_W;

    logic signed [CW:0]          diff_x;
    logic signed [CW:0]          diff_y;
    logic signed [CW:0]          neg_x;
    logic signed [CW:0]          neg_y;
    logic [CW-1:0]               abs_x;
    logic [CW-1:0]               abs_y;

    logic                        a_valid_reg;
    logic                        a_first_reg;
    logic                        a_last_reg;
    logic [nla_pkg::TAG_W-1:0]   a_tag_reg;
    logic [CW-1:0]               a_x_reg;
    logic [CW-1:0]               a_y_reg;

    logic                        b_valid_reg;
    logic                        b_first_reg;
    logic                        b_last_reg;
    logic [nla_pkg::TAG_W-1:0]   b_tag_reg;
    logic [nla_pkg::SQ_W-1:0]    b_sqx_reg;
    logic [nla_pkg::SQ_W-1:0]    b_sqy_reg;

    logic                        c_valid_reg;
    logic                        c_first_reg;
    logic                        c_last_reg;
    logic [nla_pkg::TAG_W-1:0]   c_tag_reg;
    logic [nla_pkg::SUM_W-1:0]   c_sum_reg;

    // widen by one bit so the difference cannot overflow
    assign diff_x = {probe.entry.x[CW-1], probe.entry.x} - {obs_x[CW-1], obs_x};
    assign diff_y = {probe.entry.y[CW-1], probe.entry.y} - {obs_y[CW-1], obs_y};
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign abs_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
    assign abs_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= probe.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_first_reg <= probe.first;
        a_last_reg  <= probe.last;
        a_tag_reg   <= probe.entry.tag;
        a_x_reg     <= abs_x;
        a_y_reg     <= abs_y;

        b_first_reg <= a_first_reg;
        b_last_reg  <= a_last_reg;
        b_tag_reg   <= a_tag_reg;
        b_sqx_reg   <= a_x_reg * a_x_reg;
        b_sqy_reg   <= a_y_reg * a_y_reg;

        c_first_reg <= b_first_reg;
        c_last_reg  <= b_last_reg;
        c_tag_reg   <= b_tag_reg;
        c_sum_reg   <= {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
    end

    assign result.valid  = c_valid_reg;
    assign result.first  = c_first_reg;
    assign result.last   = c_last_reg;
    assign result.tag    = c_tag_reg;
    assign result.sq_sum = c_sum_reg;

endmodule

`default_nettype wire

FILE: src/nearest_landmark_association.sv
// Nearest landmark association: landmark table, scan sequencer, running minimum.
// Depends on nla_pkg, nla_dist and nearest_landmark_association_assert.svh.
//
//   Channel  Handshake            Beat contents
//   in       in_valid/in_ready    action, pos_x, pos_y, landmark_tag
//   out      out_valid/out_ready  status, nearest_tag, nearest_dist_sq
//
// Clear and append return nothing, unless an append finds the table full.
// A query holds in_ready low while the table memory is read one entry per cycle
// into the single distance unit, then while the pipe drains.
// An empty-table query or a rejected append goes straight to the done state.
// A result waits in the output register; a later result stalls until it is taken.
// Reset empties the table at once; entries need no clearing.
`default_nettype none

`include "nearest_landmark_association_assert.svh"

module nearest_landmark_association
#(
    parameter int MAX_MARKS = nla_pkg::MAX_MARKS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         action,
    input  wire logic signed [nla_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [nla_pkg::COORD_W-1:0] pos_y,
    input  wire logic [nla_pkg::TAG_W-1:0]          landmark_tag,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              status,
    output logic [nla_pkg::TAG_W-1:0]               nearest_tag,
    output logic [nla_pkg::DIST_W-1:0]              nearest_dist_sq
);

    localparam int IDX_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int CNT_W = $clog2(MAX_MARKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MARKS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    nla_pkg::nla_entry_t mark_mem [MAX_MARKS];

    logic [1:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic signed [nla_pkg::COORD_W-1:0] obs_x_reg;
    logic signed [nla_pkg::COORD_W-1:0] obs_y_reg;

    logic                              s1_valid_reg;
    logic                              s1_first_reg;
    logic                              s1_last_reg;
    nla_pkg::nla_entry_t               rd_entry_reg;

    logic [nla_pkg::SUM_W-1:0]         best_reg;
    logic [nla_pkg::TAG_W-1:0]         best_tag_reg;
    logic [1:0]                        pend_status_reg;
    logic [nla_pkg::TAG_W-1:0]         pend_tag_reg;
    logic [nla_pkg::SUM_W-1:0]         pend_dist_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [1:0]                        out_status_reg;
    logic [nla_pkg::TAG_W-1:0]         out_tag_reg;
    logic [nla_pkg::SUM_W-1:0]         out_dist_reg;

    logic                              accept;
    logic                              issue;
    logic                              issue_last;
    logic                              full;
    logic                              take_new;
    logic                              out_free;
    logic                              do_write;
    logic [nla_pkg::SUM_W-1:0]         new_best;
    logic [nla_pkg::TAG_W-1:0]         new_tag;
    nla_pkg::nla_probe_t               probe;
    nla_pkg::nla_dist_t                dres;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign full       = (count_reg == CNT_MAX);
    assign issue      = (state_reg == S_SCAN);
    assign issue_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign do_write   = accept && (action == nla_pkg::ACT_APPEND) && !full;

    // first entry always wins; later ones only on a strictly smaller distance
    assign take_new = dres.first || (dres.sq_sum < best_reg);
    assign new_best = take_new ? dres.sq_sum : best_reg;
    assign new_tag  = take_new ? dres.tag : best_tag_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        nla_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        nla_pkg::ACT_APPEND:
                        begin
                            if (full)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        nla_pkg::ACT_QUERY:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (dres.valid && dres.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // landmark table
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mark_mem[count_reg[IDX_W-1:0]] <= '{x: pos_x, y: pos_y, tag: landmark_tag};
        end
        rd_entry_reg <= mark_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (idx_reg == '0);
        s1_last_reg  <= issue_last;
        if (accept)
        begin
            obs_x_reg <= pos_x;
            obs_y_reg <= pos_y;
        end
        if (dres.valid)
        begin
            best_reg     <= new_best;
            best_tag_reg <= new_tag;
        end
        if (accept && (action == nla_pkg::ACT_APPEND))
        begin
            pend_status_reg <= nla_pkg::ST_FULL;
            pend_tag_reg    <= '0;
            pend_dist_reg   <= '0;
        end
        else if (accept && (action == nla_pkg::ACT_QUERY))
        begin
            pend_status_reg <= nla_pkg::ST_EMPTY;
            pend_tag_reg    <= '0;
            pend_dist_reg   <= '0;
        end
        else if (dres.valid && dres.last)
        begin
            pend_status_reg <= nla_pkg::ST_FOUND;
            pend_tag_reg    <= new_tag;
            pend_dist_reg   <= new_best;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_status_reg <= pend_status_reg;
            out_tag_reg    <= pend_tag_reg;
            out_dist_reg   <= pend_dist_reg;
        end
    end

    assign probe.valid = s1_valid_reg;
    assign probe.first = s1_first_reg;
    assign probe.last  = s1_last_reg;
    assign probe.entry = rd_entry_reg;

    nla_dist u_dist
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .probe  (probe),
        .obs_x  (obs_x_reg),
        .obs_y  (obs_y_reg),
        .result (dres)
    );

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign nearest_tag     = out_tag_reg;
    assign nearest_dist_sq = nla_pkg::DIST_W'(out_dist_reg);

    `NLA_NEVER(a_count_range, count_reg > CNT_MAX, "landmark count beyond table depth")
    `NLA_ASSERT(a_dist_in_scan, dres.valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN), "distance beat outside a scan")
    `NLA_ASSERT(a_done_drained, (state_reg == S_DONE) |-> (!s1_valid_reg && !dres.valid), "pipe not drained at result")
    `NLA_ASSERT(a_empty_query, (accept && action == nla_pkg::ACT_QUERY && count_reg == '0) |=> (state_reg == S_DONE), "empty query not reported")
    `NLA_ASSERT(a_miss_zero, (out_valid_reg && out_status_reg != nla_pkg::ST_FOUND) |-> (out_tag_reg == '0 && out_dist_reg == '0), "non-zero payload on miss")

endmodule

`default_nettype wire

FILE: tb/sv/nla_result_checker.sv
// Result checker for nearest_landmark_association: watches both channels,
// keeps its own landmark table and compares every result beat.
// Depends on nla_pkg.
`default_nettype none

module nla_result_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [1:0]                         action,
    input  wire logic signed [nla_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [nla_pkg::COORD_W-1:0] pos_y,
    input  wire logic [nla_pkg::TAG_W-1:0]          landmark_tag,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [1:0]                         status,
    input  wire logic [nla_pkg::TAG_W-1:0]          nearest_tag,
    input  wire logic [nla_pkg::DIST_W-1:0]         nearest_dist_sq,
    output int                                      fail_count,
    output int                                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W   = nla_pkg::COORD_W;
    localparam int TAG_W     = nla_pkg::TAG_W;
    localparam int DIST_W    = nla_pkg::DIST_W;
    localparam int MAX_MARKS = nla_pkg::MAX_MARKS_DEF;

    typedef struct {
        logic [1:0]        status;
        logic [TAG_W-1:0]  tag;
        logic [DIST_W-1:0] dist_sq;
    } answer_t;

    answer_t                   expected_answers[$];
    logic signed [COORD_W-1:0] land_x   [MAX_MARKS];
    logic signed [COORD_W-1:0] land_y   [MAX_MARKS];
    logic [TAG_W-1:0]          land_tag [MAX_MARKS];
    int                        land_count;
    int                        mismatches;

    // Update the table for one beat; return 1 when the beat yields a result.
    function automatic bit predict_answer(
        input  logic [1:0]                act,
        input  logic signed [COORD_W-1:0] px,
        input  logic signed [COORD_W-1:0] py,
        input  logic [TAG_W-1:0]          tag,
        output answer_t                   ans
    );
        longint            dx;
        longint            dy;
        logic [DIST_W-1:0] d;
        ans.status  = nla_pkg::ST_FOUND;
        ans.tag     = '0;
        ans.dist_sq = '0;
        case (act)
            nla_pkg::ACT_CLEAR:
            begin
                land_count = 0;
                return 1'b0;
            end
            nla_pkg::ACT_APPEND:
            begin
                if (land_count >= MAX_MARKS)
                begin
                    ans.status = nla_pkg::ST_FULL;
                    return 1'b1;
                end
                land_x[land_count]   = px;
                land_y[land_count]   = py;
                land_tag[land_count] = tag;
                land_count++;
                return 1'b0;
            end
            nla_pkg::ACT_QUERY:
            begin
                if (land_count == 0)
                begin
                    ans.status = nla_pkg::ST_EMPTY;
                    return 1'b1;
                end
                for (int i = 0; i < land_count; i++)
                begin
                    dx = longint'(land_x[i]) - longint'(px);
                    dy = longint'(land_y[i]) - longint'(py);
                    d  = DIST_W'(dx * dx + dy * dy);
                    // strict compare: the earlier entry keeps a tie
                    if (i == 0 || d < ans.dist_sq)
                    begin
                        ans.dist_sq = d;
                        ans.tag     = land_tag[i];
                    end
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        if (!rst_n)
        begin
            expected_answers.delete();
            land_count = 0;
            mismatches = 0;
        end
        else
        begin
            // a result beat always belongs to an earlier input beat, so check first
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d tag %0h dist %0d",
                           status, nearest_tag, nearest_dist_sq);
                    mismatches++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (nearest_tag !== want.tag)
                    begin
                        $error("nearest_tag mismatch: expected %0h, got %0h",
                               want.tag, nearest_tag);
                        mismatches++;
                    end
                    if (nearest_dist_sq !== want.dist_sq)
                    begin
                        $error("nearest_dist_sq mismatch: expected %0d, got %0d",
                               want.dist_sq, nearest_dist_sq);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (predict_answer(action, pos_x, pos_y, landmark_tag, want))
                    expected_answers = {expected_answers, want};
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_answers.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_nearest_landmark_association.sv
// Testbench top for nearest_landmark_association: clock, reset, directed and
// random landmark traffic, output back-pressure and the verdict.
// Depends on nla_pkg, the block itself and nla_result_checker.
`default_nettype none

module tb_nearest_landmark_association;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = nla_pkg::COORD_W;
    localparam int TAG_W   = nla_pkg::TAG_W;
    localparam int DIST_W  = nla_pkg::DIST_W;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam int BEAT_TARGET = 1600;
    localparam int CALM_FROM   = 1400;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [TAG_W-1:0]          landmark_tag;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                status;
    logic [TAG_W-1:0]          nearest_tag;
    logic [DIST_W-1:0]         nearest_dist_sq;
    int                        fail_count;
    int                        pending_count;
    bit                        calm = 1'b0;
    int                        beats_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_landmark_association #(
        .MAX_MARKS (nla_pkg::MAX_MARKS_DEF)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .landmark_tag    (landmark_tag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .nearest_tag     (nearest_tag),
        .nearest_dist_sq (nearest_dist_sq)
    );

    nla_result_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .landmark_tag    (landmark_tag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .nearest_tag     (nearest_tag),
        .nearest_dist_sq (nearest_dist_sq),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    // Small coordinates crowd the landmarks together and make ties common.
    function automatic logic signed [COORD_W-1:0] pick_coord(input bit near);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return COORD_MIN;
        if (pick == 1)
            return COORD_MAX;
        if (near)
            return COORD_W'(int'($urandom_range(0, 8)) - 4);
        return COORD_W'($urandom());
    endfunction

    task automatic send_beat(
        input logic [1:0]                act,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [TAG_W-1:0]          tag
    );
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        pos_x        <= x;
        pos_y        <= y;
        landmark_tag <= tag;
        do
            @(posedge clk);
        while (!in_ready);
        if (act != ACT_UNUSED)
            beats_sent++;
    endtask

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int  seq;
        int  marks;
        bit  near;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= nla_pkg::ACT_CLEAR;
        pos_x        <= '0;
        pos_y        <= '0;
        landmark_tag <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, ignored code, corners, ties, clear
        send_beat(nla_pkg::ACT_QUERY, '0, '0, '0);
        send_beat(ACT_UNUSED, COORD_MAX, COORD_MIN, 16'hFFFF);
        send_beat(nla_pkg::ACT_APPEND, COORD_MIN, COORD_MIN, 16'hFFFF);
        send_beat(nla_pkg::ACT_QUERY, COORD_MAX, COORD_MAX, '0);
        send_beat(nla_pkg::ACT_APPEND, COORD_MAX, COORD_MAX, 16'h0000);
        send_beat(nla_pkg::ACT_QUERY, COORD_MIN, COORD_MAX, '0);
        send_beat(nla_pkg::ACT_QUERY, COORD_MAX, COORD_MAX, 16'hFFFF);
        send_beat(nla_pkg::ACT_APPEND, COORD_MIN, COORD_MIN, 16'h1234);
        send_beat(nla_pkg::ACT_QUERY, COORD_MIN, COORD_MIN, '0);
        send_beat(nla_pkg::ACT_APPEND, -24'sd1, -24'sd1, 16'h5A5A);
        send_beat(nla_pkg::ACT_QUERY, '0, '0, '0);
        send_beat(ACT_UNUSED, '0, '0, '0);
        send_beat(nla_pkg::ACT_CLEAR, COORD_MAX, COORD_MAX, 16'hFFFF);
        send_beat(nla_pkg::ACT_QUERY, COORD_MIN, COORD_MIN, 16'hFFFF);
        send_beat(nla_pkg::ACT_APPEND, 24'sd5, -24'sd5, 16'h00A5);
        send_beat(nla_pkg::ACT_QUERY, 24'sd5, -24'sd5, '0);
        send_beat(nla_pkg::ACT_QUERY, -24'sd5, 24'sd5, '0);

        // random: mostly clear / fill / query runs, some noise
        seq = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            if (beats_sent >= CALM_FROM)
                calm = 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom_range(0, 3)), pick_coord(1'b0),
                              pick_coord(1'b0), TAG_W'($urandom()));
            end
            else
            begin
                near = ($urandom_range(0, 2) == 0);
                // occasionally keep the old table and pile on top of it
                if ($urandom_range(0, 7) != 0)
                    send_beat(nla_pkg::ACT_CLEAR, pick_coord(1'b0), pick_coord(1'b0),
                              TAG_W'($urandom()));
                marks = (seq % 12 == 0)
                        ? $urandom_range(nla_pkg::MAX_MARKS_DEF - 4,
                                         nla_pkg::MAX_MARKS_DEF + 6)
                        : $urandom_range(1, 12);
                repeat (marks)
                    send_beat(nla_pkg::ACT_APPEND, pick_coord(near), pick_coord(near),
                              TAG_W'($urandom()));
                repeat ($urandom_range(1, 6))
                    send_beat(nla_pkg::ACT_QUERY, pick_coord(near), pick_coord(near),
                              TAG_W'($urandom()));
                seq++;
            end
        end
        in_valid <= 1'b0;

        // drain: let the last expectation register before waiting on it
        repeat (2) @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (pending_count != 0)
            $error("%0d expected results never arrived", pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/nla_pkg.sv
src/nla_dist.sv
src/nearest_landmark_association.sv
tb/sv/nla_result_checker.sv
tb/sv/tb_nearest_landmark_association.sv
